// ===== rtl/phv_pkg.sv =====
`default_nettype none
package phv_pkg;

    localparam int MAX_NODES_DEF      = 1024;
    localparam int ALPHABET_CODES_DEF = 32;
    localparam int SCORE_BITS_DEF     = 32;

    localparam int CMD_W  = 2;
    localparam int NODE_W = 10;
    localparam int SLOT_W = 5;
    localparam int RES_W  = 5;
    localparam int IO_W   = 32;
    localparam int LEN_W  = 11;

    localparam logic [CMD_W-1:0] CMD_LOAD_EMIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_TRANS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_SPEC  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESIDUE    = 2'd3;

    localparam logic [2:0] TR_BM = 3'd0;
    localparam logic [2:0] TR_MM = 3'd1;
    localparam logic [2:0] TR_IM = 3'd2;
    localparam logic [2:0] TR_DM = 3'd3;
    localparam logic [2:0] TR_MD = 3'd4;
    localparam logic [2:0] TR_MI = 3'd5;
    localparam logic [2:0] TR_II = 3'd6;
    localparam logic [2:0] TR_DD = 3'd7;

    localparam logic [2:0] SP_EMOVE = 3'd0;
    localparam logic [2:0] SP_ELOOP = 3'd1;
    localparam logic [2:0] SP_NMOVE = 3'd2;
    localparam logic [2:0] SP_NLOOP = 3'd3;
    localparam logic [2:0] SP_JMOVE = 3'd4;
    localparam logic [2:0] SP_JLOOP = 3'd5;
    localparam logic [2:0] SP_CMOVE = 3'd6;
    localparam logic [2:0] SP_CLOOP = 3'd7;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;   // clear sweep: write minus infinity to row entry
        logic load;         // perform load from captured item
        logic row_start;    // reset per-row carries
        logic node_read;    // issue memory reads for node
        logic node_calc;    // node data registered, compute and write back
        logic specials;     // update N/C/J/B and form result
    } phv_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/profile_hmm_viterbi_fill_core.sv =====
// Plan7 profile HMM Viterbi row engine.
// Input channel (in_valid/in_ready) carries one command item: a load of an
// emission, transition or special score, or a residue. A residue walks
// nodes 0..model_length-1 one per cycle through the shared node unit
// (memory read, then compute and write back); a residue that starts a
// sequence first sweeps the row memories to minus infinity.
// Each residue gives one result item on out_valid/out_ready: E, C, final
// score and is_last. The result sits in an output register; the next item
// is taken once the result has been taken, so a stalled receiver holds the
// block. Configuration (cfg_valid/cfg_ready) sets model_length; the
// user must do so only while the block is idle, which the block itself
// does not enforce. It is always ready. After reset the row memories are
// cleared in a pass over all MAX_NODES entries during which no item is
// accepted. N is 0; B, J, C are minus infinity.
`default_nettype none
module profile_hmm_viterbi_fill_core
    import phv_pkg::*;
#(
    parameter int MAX_NODES      = MAX_NODES_DEF,
    parameter int ALPHABET_CODES = ALPHABET_CODES_DEF,
    parameter int SCORE_BITS     = SCORE_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [LEN_W-1:0]    model_length,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [NODE_W-1:0]   node_index,
    input  wire logic [SLOT_W-1:0]   slot,
    input  wire logic [IO_W-1:0]     score_value,
    input  wire logic [RES_W-1:0]    residue,
    input  wire logic                first_of_sequence,
    input  wire logic                last_of_sequence,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [IO_W-1:0]          row_end_score,
    output logic [IO_W-1:0]          row_c_score,
    output logic [IO_W-1:0]          final_score,
    output logic                     is_last
);
    localparam int NA_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] len_next;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (model_length == '0)
            len_next = CNT_W'(1);
        else if (32'(model_length) > MAX_NODES)
            len_next = CNT_W'(MAX_NODES);
        else
            len_next = CNT_W'(model_length);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= CNT_W'(1);
        else if (cfg_valid)
            len_reg <= len_next;
    end

    logic [CMD_W-1:0]  cmd_reg;
    logic [NODE_W-1:0] node_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [IO_W-1:0]   score_reg;
    logic [RES_W-1:0]  res_reg;
    logic              first_reg, last_reg;
    logic              capture;
    phv_cmd_t          cmd;
    logic [NA_W-1:0]   node;

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            cmd_reg   <= command;
            node_reg  <= node_index;
            slot_reg  <= slot;
            score_reg <= score_value;
            res_reg   <= residue;
            first_reg <= first_of_sequence;
            last_reg  <= last_of_sequence;
        end
    end

    phv_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_command(command),
        .in_first  (first_reg),
        .length    (len_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .capture   (capture),
        .cmd       (cmd),
        .node      (node)
    );

    phv_datapath #(
        .MAX_NODES     (MAX_NODES),
        .ALPHABET_CODES(ALPHABET_CODES),
        .SCORE_BITS    (SCORE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .node        (node),
        .item_command(cmd_reg),
        .item_node   (node_reg),
        .item_slot   (slot_reg),
        .item_score  (score_reg),
        .item_residue(res_reg),
        .item_first  (first_reg),
        .item_last   (last_reg),
        .res_end     (row_end_score),
        .res_c       (row_c_score),
        .res_final   (final_score),
        .res_last    (is_last)
    );

endmodule
`default_nettype wire

// ===== rtl/phv_datapath.sv =====
`default_nettype none
module phv_datapath
    import phv_pkg::*;
#(
    parameter int MAX_NODES      = MAX_NODES_DEF,
    parameter int ALPHABET_CODES = ALPHABET_CODES_DEF,
    parameter int SCORE_BITS     = SCORE_BITS_DEF,
    localparam int NA_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
    localparam int AC_W = $clog2(ALPHABET_CODES)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire phv_cmd_t              cmd,
    input  wire logic [NA_W-1:0]       node,
    input  wire logic [CMD_W-1:0]      item_command,
    input  wire logic [NODE_W-1:0]     item_node,
    input  wire logic [SLOT_W-1:0]     item_slot,
    input  wire logic [IO_W-1:0]       item_score,
    input  wire logic [RES_W-1:0]      item_residue,
    input  wire logic                  item_first,
    input  wire logic                  item_last,
    output logic [IO_W-1:0]            res_end,
    output logic [IO_W-1:0]            res_c,
    output logic [IO_W-1:0]            res_final,
    output logic                       res_last
);
    typedef logic signed [SCORE_BITS-1:0] sc_t;
    localparam sc_t NEG = {1'b1, {(SCORE_BITS-1){1'b0}}};
    localparam sc_t POS = {1'b0, {(SCORE_BITS-1){1'b1}}};

    function automatic sc_t sadd(sc_t a, sc_t b);
        logic signed [SCORE_BITS:0] s;
        s = {a[SCORE_BITS-1], a} + {b[SCORE_BITS-1], b};
        if (a == NEG || b == NEG || s <= $signed({NEG[SCORE_BITS-1], NEG}))
            return NEG;
        if (s > $signed({1'b0, POS}))
            return POS;
        return s[SCORE_BITS-1:0];
    endfunction

    function automatic sc_t smax(sc_t a, sc_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic sc_t from_io(logic [IO_W-1:0] v);
        logic signed [63:0] w;
        w = 64'($signed(v));
        if (w <= 64'($signed(NEG)))
            return NEG;
        if (w > 64'($signed(POS)))
            return POS;
        return w[SCORE_BITS-1:0];
    endfunction

    function automatic logic [IO_W-1:0] to_io(sc_t v);
        logic signed [63:0] w;
        w = 64'(v);
        if (v == NEG || w < -64'sd2147483648)
            return 32'h8000_0000;
        if (w > 64'sd2147483647)
            return 32'h7fff_ffff;
        return w[IO_W-1:0];
    endfunction

    // memories
    sc_t emit_mem  [MAX_NODES*(1 << AC_W)];
    sc_t m_mem     [MAX_NODES];
    sc_t i_mem     [MAX_NODES];
    sc_t d_mem     [MAX_NODES];
    sc_t spec_reg  [8];

    sc_t load_val;
    assign load_val = from_io(item_score);

    logic node_ok, emit_ok, res_ok;
    assign node_ok = 32'(item_node) < 32'(MAX_NODES);
    assign emit_ok = 32'(item_slot) < 32'(ALPHABET_CODES);
    assign res_ok  = 32'(item_residue) < 32'(ALPHABET_CODES);

    logic [NA_W-1:0] ld_node;
    assign ld_node = NA_W'(item_node);

    // write ports for emission and specials
    always_ff @(posedge clk)
    begin
        if (cmd.load && item_command == CMD_LOAD_EMIT && node_ok && emit_ok)
            emit_mem[{ld_node, AC_W'(item_slot)}] <= load_val;
        if (cmd.load && item_command == CMD_LOAD_SPEC && item_slot[4:3] == 2'b00)
            spec_reg[item_slot[2:0]] <= load_val;
    end

    sc_t em_rd_reg, om_reg, oi_reg, od_reg;
    sc_t t_rd_reg [8];
    logic res_ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.node_read)
        begin
            em_rd_reg  <= emit_mem[{node, AC_W'(item_residue)}];
            om_reg     <= m_mem[node];
            oi_reg     <= i_mem[node];
            od_reg     <= d_mem[node];
            res_ok_reg <= res_ok;
        end
    end

    // one transition memory per kind, each read at one address a cycle
    for (genvar g = 0; g < 8; g++)
    begin : g_tr
        sc_t tr_mem [MAX_NODES];
        always_ff @(posedge clk)
        begin
            if (cmd.load && item_command == CMD_LOAD_TRANS && node_ok
                && item_slot == SLOT_W'(g))
                tr_mem[ld_node] <= load_val;
            if (cmd.node_read)
                t_rd_reg[g] <= tr_mem[node];
        end
    end

    // node computation
    sc_t pm_reg, pi_reg, pd_reg, cm_reg, cd_reg, mdt_reg, ddt_reg, e_reg;
    sc_t n_reg, b_reg, j_reg, c_reg;
    logic [NA_W-1:0] wr_node_reg;

    sc_t em, s1, s2, s3, s4, s_val, d_val, i_val;
    always_comb
    begin
        em    = res_ok_reg ? em_rd_reg : NEG;
        s1    = sadd(b_reg, t_rd_reg[TR_BM]);
        s2    = smax(s1, sadd(pm_reg, t_rd_reg[TR_MM]));
        s3    = smax(s2, sadd(pi_reg, t_rd_reg[TR_IM]));
        s4    = smax(s3, sadd(pd_reg, t_rd_reg[TR_DM]));
        s_val = sadd(s4, em);
        d_val = smax(sadd(cm_reg, mdt_reg), sadd(cd_reg, ddt_reg));
        i_val = smax(sadd(om_reg, t_rd_reg[TR_MI]), sadd(oi_reg, t_rd_reg[TR_II]));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.node_read)
            wr_node_reg <= node;
        if (cmd.clear_step)
        begin
            m_mem[node] <= NEG;
            i_mem[node] <= NEG;
            d_mem[node] <= NEG;
        end
        else if (cmd.node_calc)
        begin
            m_mem[wr_node_reg] <= s_val;
            i_mem[wr_node_reg] <= i_val;
            d_mem[wr_node_reg] <= d_val;
        end
    end

    sc_t n_new, c_new, j_new, b_new;
    always_comb
    begin
        n_new = sadd(n_reg, spec_reg[SP_NLOOP]);
        c_new = smax(sadd(c_reg, spec_reg[SP_CLOOP]), sadd(e_reg, spec_reg[SP_EMOVE]));
        j_new = smax(sadd(j_reg, spec_reg[SP_JLOOP]), sadd(e_reg, spec_reg[SP_ELOOP]));
        b_new = smax(sadd(j_new, spec_reg[SP_JMOVE]), sadd(n_new, spec_reg[SP_NMOVE]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
            b_reg <= NEG;
            j_reg <= NEG;
            c_reg <= NEG;
        end
        else if (cmd.row_start && item_first)
        begin
            n_reg <= '0;
            b_reg <= spec_reg[SP_NMOVE];
            j_reg <= NEG;
            c_reg <= NEG;
        end
        else if (cmd.specials)
        begin
            n_reg <= n_new;
            b_reg <= b_new;
            j_reg <= j_new;
            c_reg <= c_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_start)
        begin
            pm_reg  <= NEG;
            pi_reg  <= NEG;
            pd_reg  <= NEG;
            cm_reg  <= NEG;
            cd_reg  <= NEG;
            mdt_reg <= NEG;
            ddt_reg <= NEG;
            e_reg   <= NEG;
        end
        else if (cmd.node_calc)
        begin
            pm_reg  <= om_reg;
            pi_reg  <= oi_reg;
            pd_reg  <= od_reg;
            cm_reg  <= s_val;
            cd_reg  <= d_val;
            mdt_reg <= t_rd_reg[TR_MD];
            ddt_reg <= t_rd_reg[TR_DD];
            e_reg   <= smax(e_reg, s_val);
        end
        if (cmd.specials)
        begin
            res_end   <= to_io(e_reg);
            res_c     <= to_io(c_new);
            res_final <= item_last ? to_io(sadd(c_new, spec_reg[SP_CMOVE])) : '0;
            res_last  <= item_last;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/phv_ctrl.sv =====
`default_nettype none
module phv_ctrl
    import phv_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int NA_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
    localparam int CNT_W = $clog2(MAX_NODES + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CMD_W-1:0]  in_command,
    input  wire logic              in_first,
    input  wire logic [CNT_W-1:0]  length,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   capture,
    output phv_cmd_t               cmd,
    output logic [NA_W-1:0]        node
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_START, S_WIPE, S_RUN, S_SPEC
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0] rd_cnt_reg;   // nodes issued
    logic [CNT_W-1:0] wr_cnt_reg;   // nodes written back
    logic busy_calc_reg;
    logic out_valid_reg;

    logic last_issue;
    assign last_issue = (rd_cnt_reg + CNT_W'(1)) == length;

    assign node      = NA_W'(rd_cnt_reg);
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign capture   = in_valid && in_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.clear_step = (state_reg == S_CLEAR) || (state_reg == S_WIPE);
        cmd.load       = (state_reg == S_LOAD);
        cmd.row_start  = (state_reg == S_START);
        cmd.node_read  = (state_reg == S_RUN) && (rd_cnt_reg < length);
        cmd.node_calc  = busy_calc_reg;
        cmd.specials   = (state_reg == S_SPEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rd_cnt_reg    <= '0;
            wr_cnt_reg    <= '0;
            busy_calc_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            busy_calc_reg <= cmd.node_read;
            case (state_reg)
                S_CLEAR, S_WIPE:
                begin
                    if (32'(rd_cnt_reg) == MAX_NODES - 1)
                    begin
                        rd_cnt_reg <= '0;
                        state_reg  <= (state_reg == S_CLEAR) ? S_IDLE : S_RUN;
                    end
                    else
                        rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                end
                S_IDLE:
                begin
                    if (capture)
                        state_reg <= (in_command == CMD_RESIDUE) ? S_START : S_LOAD;
                end
                S_LOAD:
                    state_reg <= S_IDLE;
                S_START:
                begin
                    rd_cnt_reg <= '0;
                    wr_cnt_reg <= '0;
                    state_reg  <= in_first ? S_WIPE : S_RUN;
                end
                S_RUN:
                begin
                    if (cmd.node_read && !last_issue)
                        rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                    else if (cmd.node_read)
                        rd_cnt_reg <= length;
                    if (busy_calc_reg)
                    begin
                        wr_cnt_reg <= wr_cnt_reg + CNT_W'(1);
                        if (wr_cnt_reg + CNT_W'(1) == length)
                            state_reg <= S_SPEC;
                    end
                end
                S_SPEC:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/phv_checker.sv =====
`default_nettype none
module phv_checker
    import phv_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire logic [IO_W-1:0] final_score,
    input wire logic            is_last
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(final_score))
        else $error("result dropped while stalled");

    a_no_take_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("item taken while result pending");

    a_final_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> final_score == '0)
        else $error("final score set on non-last row");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");

endmodule

bind profile_hmm_viterbi_fill_core phv_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .final_score(final_score),
    .is_last    (is_last)
);
`default_nettype wire
